@@ src/slp_pkg.sv @@
`timescale 1ns / 1ps

package slp_pkg;

	typedef enum logic [2:0] {
		PH_SEARCH,
		PH_SLOT,
		PH_STATUS_FIRST,
		PH_STATUS_FIFTH,
		PH_NUMBER,
		PH_NAME,
		PH_DATETIME,
		PH_MESSAGE
	} phase_t;

	localparam logic [2:0] KIND_SLOT     = 3'd0;
	localparam logic [2:0] KIND_STATUS   = 3'd1;
	localparam logic [2:0] KIND_NUMBER   = 3'd2;
	localparam logic [2:0] KIND_DATETIME = 3'd3;
	localparam logic [2:0] KIND_MESSAGE  = 3'd4;
	localparam logic [2:0] KIND_END      = 3'd5;

	localparam logic [15:0] STAT_UNREAD  = 16'd0;
	localparam logic [15:0] STAT_READ    = 16'd1;
	localparam logic [15:0] STAT_UNSENT  = 16'd2;
	localparam logic [15:0] STAT_SENT    = 16'd3;
	localparam logic [15:0] STAT_ALL     = 16'd4;
	localparam logic [15:0] STAT_UNKNOWN = 16'd5;

	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_C     = 8'h43;
	localparam logic [7:0] CH_M     = 8'h4D;
	localparam logic [7:0] CH_G     = 8'h47;
	localparam logic [7:0] CH_L     = 8'h4C;
	localparam logic [7:0] CH_R     = 8'h52;
	localparam logic [7:0] CH_U     = 8'h55;
	localparam logic [7:0] CH_S     = 8'h53;
	localparam logic [7:0] CH_A     = 8'h41;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam logic [2:0] HDR_LEN = 3'd5;

	// "+CMGL", one character per match position
	function automatic logic [7:0] header_char(input logic [2:0] pos);
		logic [7:0] c;
		begin
			case (pos)
				3'd0:    c = CH_PLUS;
				3'd1:    c = CH_C;
				3'd2:    c = CH_M;
				3'd3:    c = CH_G;
				3'd4:    c = CH_L;
				default: c = CH_PLUS;
			endcase
			return c;
		end
	endfunction

endpackage

@@ src/slp_if.sv @@
`timescale 1ns / 1ps

interface slp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_buffer;

	modport source (output valid, output data_byte, output end_of_buffer, input ready);
	modport sink   (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

interface slp_out_if;
	logic        valid;
	logic        ready;
	logic [3:0]  record_index;
	logic [2:0]  kind;
	logic [15:0] value;
	logic        truncated;

	modport source (output valid, output record_index, output kind, output value,
		output truncated, input ready);
	modport sink   (input valid, input record_index, input kind, input value,
		input truncated, output ready);
endinterface

@@ src/sms_list_response_parser.sv @@
`timescale 1ns / 1ps

// Message-list reply parser.
// reply  : one byte of the modem reply per word (carriage returns removed),
//          end_of_buffer marks the last byte of a reply.
// result : tagged words - slot number, status code, number/date-time/message
//          characters and a record end carrying the truncated flag.
// Each byte is handled by the phase machine; its result, if any, sits in
// the output register from the cycle after the byte is taken.
// Throughput is one byte per cycle, set by the single result register: a
// new byte is taken whenever that register is empty or being emptied.
// Bytes that yield no result (header hunting, skips, name field) still
// pass through the phase machine like any other byte.
// If the receiver stalls with a result held, reply.ready drops until that
// word is taken; nothing is lost or repeated.
// Reset puts the parser in header search with the record count cleared and
// the output register empty.
module sms_list_response_parser #(
	parameter int MAX_RECORDS  = 16,
	parameter int NUMBER_LEN   = 32,
	parameter int DATETIME_LEN = 32,
	parameter int MESSAGE_LEN  = 255
) (
	input  logic clk,
	input  logic arst_n,
	slp_in_if.sink    reply,
	slp_out_if.source result
);

	localparam int CW = $clog2(MAX_RECORDS + 1);
	localparam logic [CW-1:0] REC_MAX    = CW'(MAX_RECORDS);
	localparam logic [7:0]    NUMBER_CAP = 8'(NUMBER_LEN);
	localparam logic [7:0]    DT_CAP     = 8'(DATETIME_LEN);
	localparam logic [7:0]    MSG_CAP    = 8'(MESSAGE_LEN);

	slp_pkg::phase_t phase_q, phase_d;
	logic [2:0]    hmc_q, hmc_d;
	logic [3:0]    skip_q, skip_d;
	logic [15:0]   slot_q, slot_d;
	logic          first_s_q, first_s_d;
	logic [7:0]    flen_q, flen_d;
	logic [CW-1:0] rec_cnt_q, rec_cnt_d;
	logic          dropped_q, dropped_d;

	logic          out_valid_q;
	logic [3:0]    out_idx_q;
	logic [2:0]    out_kind_q;
	logic [15:0]   out_value_q;
	logic          out_trunc_q;

	logic          accept;
	logic [7:0]    b;
	logic          silent, skipping, is_digit, is_quote, is_nl, room;
	logic [7:0]    cap;
	logic [19:0]   slot_mac;
	logic [15:0]   slot_next;
	logic [15:0]   fifth_code;
	logic          fifth_ok;
	logic [CW+3:0] rec_wide;
	logic [3:0]    rec_idx;

	logic          res_valid;
	logic [3:0]    res_idx;
	logic [2:0]    res_kind;
	logic [15:0]   res_value;
	logic          res_trunc;

	assign reply.ready = !out_valid_q || result.ready;
	assign accept      = reply.valid && reply.ready;
	assign b           = reply.data_byte;

	assign silent   = rec_cnt_q >= REC_MAX;
	assign skipping = (phase_q != slp_pkg::PH_SEARCH) && (skip_q != 4'd0);
	assign is_digit = (b >= slp_pkg::CH_ZERO) && (b <= slp_pkg::CH_NINE);
	assign is_quote = b == slp_pkg::CH_QUOTE;
	assign is_nl    = b == slp_pkg::CH_NL;
	assign rec_wide = {4'd0, rec_cnt_q};
	assign rec_idx  = rec_wide[3:0];

	always_comb begin
		case (phase_q)
			slp_pkg::PH_NUMBER:   cap = NUMBER_CAP;
			slp_pkg::PH_DATETIME: cap = DT_CAP;
			default:              cap = MSG_CAP;
		endcase
	end
	assign room = flen_q < cap;

	// acc * 10 + digit, saturated to 16 bits
	assign slot_mac  = {1'b0, slot_q, 3'd0} + {3'd0, slot_q, 1'b0} + {12'd0, b - slp_pkg::CH_ZERO};
	assign slot_next = (slot_mac > 20'd65535) ? 16'hFFFF : slot_mac[15:0];

	always_comb begin
		fifth_ok   = 1'b1;
		fifth_code = slp_pkg::STAT_UNKNOWN;
		if (b == slp_pkg::CH_U) begin
			fifth_code = first_s_q ? slp_pkg::STAT_UNSENT : slp_pkg::STAT_UNREAD;
		end else if (!first_s_q && b == slp_pkg::CH_R) begin
			fifth_code = slp_pkg::STAT_READ;
		end else if (first_s_q && b == slp_pkg::CH_S) begin
			fifth_code = slp_pkg::STAT_SENT;
		end else begin
			fifth_ok = 1'b0;
		end
	end

	// next state
	always_comb begin
		phase_d   = phase_q;
		hmc_d     = hmc_q;
		skip_d    = skip_q;
		slot_d    = slot_q;
		first_s_d = first_s_q;
		flen_d    = flen_q;
		rec_cnt_d = rec_cnt_q;
		dropped_d = dropped_q;
		if (skipping) begin
			skip_d = skip_q - 4'd1;
		end else begin
			unique case (phase_q)
				slp_pkg::PH_SEARCH: begin
					if (b == slp_pkg::header_char(hmc_q)) begin
						if (hmc_q == slp_pkg::HDR_LEN - 3'd1) begin
							hmc_d     = 3'd0;
							phase_d   = slp_pkg::PH_SLOT;
							skip_d    = 4'd2;
							slot_d    = 16'd0;
							dropped_d = 1'b0;
						end else begin
							hmc_d = hmc_q + 3'd1;
						end
					end else begin
						hmc_d = (b == slp_pkg::CH_PLUS) ? 3'd1 : 3'd0;
					end
				end
				slp_pkg::PH_SLOT: begin
					if (is_digit) begin
						slot_d = slot_next;
					end else begin
						phase_d = slp_pkg::PH_STATUS_FIRST;
						skip_d  = 4'd1;
					end
				end
				slp_pkg::PH_STATUS_FIRST: begin
					if (b == slp_pkg::CH_R || b == slp_pkg::CH_S) begin
						first_s_d = b == slp_pkg::CH_S;
						phase_d   = slp_pkg::PH_STATUS_FIFTH;
						skip_d    = 4'd3;
					end else begin
						phase_d = slp_pkg::PH_NUMBER;
						skip_d  = (b == slp_pkg::CH_A) ? 4'd9 : 4'd2;
						flen_d  = 8'd0;
					end
				end
				slp_pkg::PH_STATUS_FIFTH: begin
					if (fifth_ok) begin
						phase_d = slp_pkg::PH_NUMBER;
						skip_d  = (b == slp_pkg::CH_U) ? 4'd8 : 4'd6;
						flen_d  = 8'd0;
					end else begin
						phase_d = slp_pkg::PH_SEARCH;
						hmc_d   = 3'd0;
						skip_d  = 4'd0;
					end
				end
				slp_pkg::PH_NUMBER: begin
					if (is_quote) begin
						phase_d = slp_pkg::PH_NAME;
						skip_d  = 4'd2;
					end else if (room) begin
						flen_d = flen_q + 8'd1;
					end else begin
						dropped_d = 1'b1;
					end
				end
				slp_pkg::PH_NAME: begin
					if (is_quote) begin
						phase_d = slp_pkg::PH_DATETIME;
						skip_d  = 4'd2;
						flen_d  = 8'd0;
					end
				end
				slp_pkg::PH_DATETIME: begin
					if (is_quote) begin
						phase_d = slp_pkg::PH_MESSAGE;
						skip_d  = 4'd1;
						flen_d  = 8'd0;
					end else if (room) begin
						flen_d = flen_q + 8'd1;
					end else begin
						dropped_d = 1'b1;
					end
				end
				slp_pkg::PH_MESSAGE: begin
					if (is_nl) begin
						if (!silent) begin
							rec_cnt_d = rec_cnt_q + CW'(1);
						end
						phase_d = slp_pkg::PH_SEARCH;
						hmc_d   = 3'd0;
						skip_d  = 4'd0;
					end else if (room) begin
						flen_d = flen_q + 8'd1;
					end else begin
						dropped_d = 1'b1;
					end
				end
			endcase
		end
		if (reply.end_of_buffer) begin
			phase_d   = slp_pkg::PH_SEARCH;
			hmc_d     = 3'd0;
			skip_d    = 4'd0;
			rec_cnt_d = '0;
		end
	end

	// result word for this byte
	always_comb begin
		res_valid = 1'b0;
		res_idx   = rec_idx;
		res_kind  = slp_pkg::KIND_SLOT;
		res_value = 16'd0;
		res_trunc = 1'b0;
		if (!skipping) begin
			unique case (phase_q)
				slp_pkg::PH_SEARCH, slp_pkg::PH_NAME: begin
					res_valid = 1'b0;
				end
				slp_pkg::PH_SLOT: begin
					res_valid = !is_digit && !silent;
					res_kind  = slp_pkg::KIND_SLOT;
					res_value = slot_q;
				end
				slp_pkg::PH_STATUS_FIRST: begin
					res_valid = !(b == slp_pkg::CH_R || b == slp_pkg::CH_S) && !silent;
					res_kind  = slp_pkg::KIND_STATUS;
					res_value = (b == slp_pkg::CH_A) ? slp_pkg::STAT_ALL : slp_pkg::STAT_UNKNOWN;
				end
				slp_pkg::PH_STATUS_FIFTH: begin
					res_valid = fifth_ok && !silent;
					res_kind  = slp_pkg::KIND_STATUS;
					res_value = fifth_code;
				end
				slp_pkg::PH_NUMBER: begin
					res_valid = !is_quote && room && !silent;
					res_kind  = slp_pkg::KIND_NUMBER;
					res_value = {8'd0, b};
				end
				slp_pkg::PH_DATETIME: begin
					res_valid = !is_quote && room && !silent;
					res_kind  = slp_pkg::KIND_DATETIME;
					res_value = {8'd0, b};
				end
				slp_pkg::PH_MESSAGE: begin
					if (is_nl) begin
						res_valid = 1'b1;
						res_kind  = slp_pkg::KIND_END;
						res_idx   = silent ? 4'd15 : rec_idx;
						res_trunc = silent ? 1'b1 : dropped_q;
					end else begin
						res_valid = room && !silent;
						res_kind  = slp_pkg::KIND_MESSAGE;
						res_value = {8'd0, b};
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= slp_pkg::PH_SEARCH;
			hmc_q     <= 3'd0;
			skip_q    <= 4'd0;
			slot_q    <= 16'd0;
			first_s_q <= 1'b0;
			flen_q    <= 8'd0;
			rec_cnt_q <= '0;
			dropped_q <= 1'b0;
		end else if (accept) begin
			phase_q   <= phase_d;
			hmc_q     <= hmc_d;
			skip_q    <= skip_d;
			slot_q    <= slot_d;
			first_s_q <= first_s_d;
			flen_q    <= flen_d;
			rec_cnt_q <= rec_cnt_d;
			dropped_q <= dropped_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= res_valid;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && res_valid) begin
			out_idx_q   <= res_idx;
			out_kind_q  <= res_kind;
			out_value_q <= res_value;
			out_trunc_q <= res_trunc;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.record_index = out_idx_q;
	assign result.kind         = out_kind_q;
	assign result.value        = out_value_q;
	assign result.truncated    = out_trunc_q;

endmodule

@@ tb/tb_sms_list_response_parser.sv @@
`timescale 1ns / 1ps

module tb_sms_list_response_parser;

	localparam int MAX_RECORDS  = 16;
	localparam int NUMBER_LEN   = 32;
	localparam int DATETIME_LEN = 32;
	localparam int MESSAGE_LEN  = 255;

	localparam logic [39:0] HEADER_TEXT = "+CMGL";
	// status word whose fifth character is not allowed for its first one
	localparam int ST_BAD = 6;

	class cmgl_scoreboard;
		typedef struct packed {
			logic [3:0]  rec;
			logic [2:0]  kind;
			logic [15:0] value;
			logic        trunc;
		} parse_word_t;

		slp_pkg::phase_t phase;
		logic [2:0]  hdr_pos;
		logic [3:0]  skip;
		logic [15:0] slot;
		logic        first_is_s;
		logic [7:0]  field_len;
		int          rec_count;
		logic        dropped;
		parse_word_t due_q[$];
		int          errors;

		function new();
			restart_search();
			slot       = '0;
			first_is_s = 1'b0;
			field_len  = '0;
			rec_count  = 0;
			dropped    = 1'b0;
			errors     = 0;
		endfunction

		function void restart_search();
			phase   = slp_pkg::PH_SEARCH;
			hdr_pos = '0;
			skip    = '0;
		endfunction

		function void push_word(logic [3:0] rec, logic [2:0] kind, logic [15:0] value,
			logic trunc);
			parse_word_t w;
			w.rec   = rec;
			w.kind  = kind;
			w.value = value;
			w.trunc = trunc;
			due_q.push_back(w);
		endfunction

		function void pass_char(logic [2:0] kind, int cap, logic [7:0] b, bit silent);
			if (field_len < cap) begin
				field_len++;
				if (!silent)
					push_word(rec_count[3:0], kind, {8'h00, b}, 1'b0);
			end else begin
				dropped = 1'b1;
			end
		endfunction

		// advance the parser by one accepted byte, queueing any word it yields
		function void note_byte(logic [7:0] b, logic eob);
			bit          silent;
			bit          bad;
			int          acc;
			logic [15:0] code;
			silent = (rec_count >= MAX_RECORDS);
			if (phase != slp_pkg::PH_SEARCH && skip != 0) begin
				skip--;
			end else begin
				case (phase)
					slp_pkg::PH_SEARCH: begin
						if (b == HEADER_TEXT[39 - 8 * int'(hdr_pos) -: 8]) begin
							hdr_pos++;
							if (hdr_pos == slp_pkg::HDR_LEN) begin
								hdr_pos = '0;
								phase   = slp_pkg::PH_SLOT;
								skip    = 4'd2;
								slot    = '0;
								dropped = 1'b0;
							end
						end else begin
							hdr_pos = (b == slp_pkg::CH_PLUS) ? 3'd1 : 3'd0;
						end
					end
					slp_pkg::PH_SLOT: begin
						if (b >= slp_pkg::CH_ZERO && b <= slp_pkg::CH_NINE) begin
							acc  = int'(slot) * 10 + int'(b) - int'(slp_pkg::CH_ZERO);
							slot = (acc > 65535) ? 16'hFFFF : 16'(acc);
						end else begin
							if (!silent)
								push_word(rec_count[3:0], slp_pkg::KIND_SLOT, slot, 1'b0);
							phase = slp_pkg::PH_STATUS_FIRST;
							skip  = 4'd1;
						end
					end
					slp_pkg::PH_STATUS_FIRST: begin
						if (b == slp_pkg::CH_R || b == slp_pkg::CH_S) begin
							first_is_s = (b == slp_pkg::CH_S);
							phase      = slp_pkg::PH_STATUS_FIFTH;
							skip       = 4'd3;
						end else begin
							code = (b == slp_pkg::CH_A) ? slp_pkg::STAT_ALL
								: slp_pkg::STAT_UNKNOWN;
							if (!silent)
								push_word(rec_count[3:0], slp_pkg::KIND_STATUS, code, 1'b0);
							phase     = slp_pkg::PH_NUMBER;
							skip      = (b == slp_pkg::CH_A) ? 4'd9 : 4'd2;
							field_len = '0;
						end
					end
					slp_pkg::PH_STATUS_FIFTH: begin
						bad  = 1'b0;
						code = slp_pkg::STAT_UNKNOWN;
						if (b == slp_pkg::CH_U)
							code = first_is_s ? slp_pkg::STAT_UNSENT : slp_pkg::STAT_UNREAD;
						else if (!first_is_s && b == slp_pkg::CH_R)
							code = slp_pkg::STAT_READ;
						else if (first_is_s && b == slp_pkg::CH_S)
							code = slp_pkg::STAT_SENT;
						else
							bad = 1'b1;
						if (bad) begin
							restart_search();
						end else begin
							if (!silent)
								push_word(rec_count[3:0], slp_pkg::KIND_STATUS, code, 1'b0);
							phase     = slp_pkg::PH_NUMBER;
							skip      = (b == slp_pkg::CH_U) ? 4'd8 : 4'd6;
							field_len = '0;
						end
					end
					slp_pkg::PH_NUMBER: begin
						if (b == slp_pkg::CH_QUOTE) begin
							phase = slp_pkg::PH_NAME;
							skip  = 4'd2;
						end else begin
							pass_char(slp_pkg::KIND_NUMBER, NUMBER_LEN, b, silent);
						end
					end
					slp_pkg::PH_NAME: begin
						if (b == slp_pkg::CH_QUOTE) begin
							phase     = slp_pkg::PH_DATETIME;
							skip      = 4'd2;
							field_len = '0;
						end
					end
					slp_pkg::PH_DATETIME: begin
						if (b == slp_pkg::CH_QUOTE) begin
							phase     = slp_pkg::PH_MESSAGE;
							skip      = 4'd1;
							field_len = '0;
						end else begin
							pass_char(slp_pkg::KIND_DATETIME, DATETIME_LEN, b, silent);
						end
					end
					slp_pkg::PH_MESSAGE: begin
						if (b == slp_pkg::CH_NL) begin
							if (silent) begin
								push_word(4'd15, slp_pkg::KIND_END, 16'd0, 1'b1);
							end else begin
								push_word(rec_count[3:0], slp_pkg::KIND_END, 16'd0, dropped);
								rec_count++;
							end
							restart_search();
						end else begin
							pass_char(slp_pkg::KIND_MESSAGE, MESSAGE_LEN, b, silent);
						end
					end
					default: restart_search();
				endcase
			end
			if (eob) begin
				restart_search();
				rec_count = 0;
			end
		endfunction

		task report(string msg);
			if (errors < 50)
				$display("mismatch: %s", msg);
			errors++;
		endtask

		task check_word(logic [3:0] rec, logic [2:0] kind, logic [15:0] value, logic trunc);
			parse_word_t w;
			if (due_q.size() == 0) begin
				report($sformatf("unexpected word rec %0d kind %0d value %0d trunc %0b",
					rec, kind, value, trunc));
				return;
			end
			w = due_q.pop_front();
			if (rec !== w.rec)
				report($sformatf("record_index %0d, want %0d", rec, w.rec));
			if (kind !== w.kind)
				report($sformatf("kind %0d, want %0d", kind, w.kind));
			if (value !== w.value)
				report($sformatf("value %0d, want %0d (kind %0d)", value, w.value, w.kind));
			if (trunc !== w.trunc)
				report($sformatf("truncated %0b, want %0b", trunc, w.trunc));
		endtask
	endclass

	logic clk;
	logic arst_n;
	int   src_idle;
	int   snk_idle;

	// {end_of_buffer, byte} waiting to be sent
	logic [8:0] reply_q[$];

	cmgl_scoreboard sb = new();

	slp_in_if  reply_bus();
	slp_out_if result_bus();

	sms_list_response_parser #(
		.MAX_RECORDS  (MAX_RECORDS),
		.NUMBER_LEN   (NUMBER_LEN),
		.DATETIME_LEN (DATETIME_LEN),
		.MESSAGE_LEN  (MESSAGE_LEN)
	) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.reply  (reply_bus),
		.result (result_bus)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#1_000_000;
		$display("status: fail");
		$finish;
	end

	always @(posedge clk) begin
		result_bus.ready <= ($urandom_range(99) >= snk_idle);
	end

	always @(posedge clk) begin
		if (arst_n && result_bus.valid && result_bus.ready)
			sb.check_word(result_bus.record_index, result_bus.kind, result_bus.value,
				result_bus.truncated);
	end

	function automatic void queue_text(string s);
		for (int i = 0; i < s.len(); i++)
			reply_q.push_back({1'b0, s[i]});
	endfunction

	function automatic void queue_field(int n, logic [7:0] stop);
		logic [7:0] b;
		repeat (n) begin
			do b = 8'($urandom_range(255)); while (b == stop);
			reply_q.push_back({1'b0, b});
		end
	endfunction

	// one listing entry laid out so that the fixed skips land on the fields
	function automatic void queue_record(string slot_txt, int st, int nlen, int namelen,
		int dlen, int mlen);
		logic [7:0] first;
		logic [7:0] c;
		queue_text("+CMGL: ");
		queue_text(slot_txt);
		queue_text(",\"");
		case (st)
			slp_pkg::STAT_UNREAD:  queue_text("REC UNREAD\",\"");
			slp_pkg::STAT_READ:    queue_text("REC READ\",\"");
			slp_pkg::STAT_UNSENT:  queue_text("STO UNSENT\",\"");
			slp_pkg::STAT_SENT:    queue_text("STO SENT\",\"");
			slp_pkg::STAT_ALL:     queue_text("ALL    \",\"");
			slp_pkg::STAT_UNKNOWN: begin
				do c = 8'($urandom_range(255));
				while (c == slp_pkg::CH_R || c == slp_pkg::CH_S || c == slp_pkg::CH_A);
				reply_q.push_back({1'b0, c});
				queue_text(",\"");
			end
			default: begin
				first = ($urandom_range(1) == 0) ? slp_pkg::CH_R : slp_pkg::CH_S;
				do c = 8'($urandom_range(255)); while (c == slp_pkg::CH_U || c == first);
				reply_q.push_back({1'b0, first});
				queue_text("EC ");
				reply_q.push_back({1'b0, c});
				queue_text("EAD\",\"");
			end
		endcase
		queue_field(nlen, slp_pkg::CH_QUOTE);
		queue_text("\",\"");
		queue_field(namelen, slp_pkg::CH_QUOTE);
		queue_text("\",\"");
		queue_field(dlen, slp_pkg::CH_QUOTE);
		queue_text("\"\n");
		queue_field(mlen, slp_pkg::CH_NL);
		reply_q.push_back({1'b0, slp_pkg::CH_NL});
	endfunction

	// reply ends early: keep bytes up to index last, flag end of buffer there
	function automatic void cut_reply(int last);
		while (reply_q.size() > last + 1)
			void'(reply_q.pop_back());
		reply_q[last][8] = 1'b1;
	endfunction

	function automatic void queue_noise(int n);
		logic [7:0] b;
		repeat (n) begin
			b = ($urandom_range(1) == 0) ? HEADER_TEXT[8 * $urandom_range(4) +: 8]
				: 8'($urandom_range(255));
			reply_q.push_back({($urandom_range(19) == 0), b});
		end
	endfunction

	function automatic int queue_random_record();
		int    start;
		int    st;
		int    nlen;
		int    dlen;
		int    mlen;
		string slot_txt;
		start = reply_q.size();
		case ($urandom_range(9))
			0:       slot_txt = "";
			1:       slot_txt = $sformatf("%0d", $urandom_range(9999999));
			default: slot_txt = $sformatf("%0d", $urandom_range(65535));
		endcase
		st   = ($urandom_range(99) < 8) ? ST_BAD : $urandom_range(slp_pkg::STAT_UNKNOWN);
		nlen = ($urandom_range(19) == 0) ? $urandom_range(NUMBER_LEN + 8, NUMBER_LEN + 1)
			: $urandom_range(12);
		dlen = ($urandom_range(19) == 0) ? $urandom_range(DATETIME_LEN + 4, DATETIME_LEN + 1)
			: $urandom_range(20);
		mlen = ($urandom_range(49) == 0) ? $urandom_range(MESSAGE_LEN + 7, MESSAGE_LEN - 5)
			: $urandom_range(16);
		queue_record(slot_txt, st, nlen, $urandom_range(6), dlen, mlen);
		if ($urandom_range(19) == 0)
			cut_reply($urandom_range(reply_q.size() - 1, start));
		else if ($urandom_range(9) == 0)
			reply_q[$][8] = 1'b1;
		return reply_q.size() - start;
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic eob);
		if ($urandom_range(99) < src_idle) begin
			reply_bus.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < src_idle);
		end
		reply_bus.valid         <= 1'b1;
		reply_bus.data_byte     <= b;
		reply_bus.end_of_buffer <= eob;
		do @(posedge clk); while (!reply_bus.ready);
		sb.note_byte(b, eob);
	endtask

	task automatic send_queued(input logic eob_last);
		logic [8:0] w;
		if (eob_last && reply_q.size() != 0)
			reply_q[$][8] = 1'b1;
		while (reply_q.size() != 0) begin
			w = reply_q.pop_front();
			send_byte(w[7:0], w[8]);
		end
	endtask

	task automatic wait_for_results();
		reply_bus.valid <= 1'b0;
		do @(posedge clk); while (sb.due_q.size() != 0);
	endtask

	initial begin
		int sent;
		bit paused;
		reply_bus.valid         = 1'b0;
		reply_bus.data_byte     = '0;
		reply_bus.end_of_buffer = 1'b0;
		result_bus.ready        = 1'b0;
		arst_n                  = 1'b0;
		src_idle                = 13;
		snk_idle                = 47;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// stray text and broken headers, then every status form
		queue_text("OK\n+C+CM+CMG+CMGX");
		reply_q.push_back({1'b0, 8'h00});
		reply_q.push_back({1'b0, 8'hFF});
		queue_record("0", slp_pkg::STAT_UNREAD, 4, 3, 5, 3);
		queue_record("65535", slp_pkg::STAT_READ, 2, 0, 4, 6);
		queue_record("99999999", slp_pkg::STAT_UNSENT, 1, 1, 1, 1);
		queue_record("", slp_pkg::STAT_SENT, 3, 2, 2, 2);
		queue_record("12", slp_pkg::STAT_ALL, 0, 0, 0, 0);
		queue_record("3", slp_pkg::STAT_UNKNOWN, 5, 1, 3, 4);
		queue_record("4", ST_BAD, 3, 1, 3, 3);
		queue_record("4", ST_BAD, 3, 1, 3, 3);
		// newlines inside number, name and date/time are plain characters
		queue_text("+CMGL: 7,\"REC READ\",\"+1\n2\",\"A\nB\",\"24\n01\"\nhi\n");
		send_queued(1'b1);

		// overlong fields, then fields exactly at their limits
		queue_record("5", slp_pkg::STAT_READ, NUMBER_LEN + 8, 3, DATETIME_LEN + 4,
			MESSAGE_LEN + 5);
		queue_record("6", slp_pkg::STAT_UNREAD, NUMBER_LEN, 0, DATETIME_LEN, MESSAGE_LEN);
		send_queued(1'b0);

		// past the record limit within one reply
		repeat (MAX_RECORDS + 2) queue_record("1", slp_pkg::STAT_UNKNOWN, 1, 0, 1, 1);
		send_queued(1'b1);

		// reply ends inside the number; the next one starts clean
		queue_record("8", slp_pkg::STAT_SENT, 6, 0, 2, 2);
		cut_reply(24);
		queue_record("9", slp_pkg::STAT_READ, 2, 1, 2, 2);
		send_queued(1'b0);

		for (int p = 0; p < 3; p++) begin
			case (p)
				0: begin src_idle = 13; snk_idle = 47; end
				1: begin src_idle = 47; snk_idle = 13; end
				default: begin src_idle = 0; snk_idle = 0; end
			endcase
			sent   = 0;
			paused = 1'b0;
			while (sent < 220) begin
				if ($urandom_range(99) < 15)
					queue_noise($urandom_range(12, 1));
				else
					sent += queue_random_record();
				send_queued(1'b0);
				if (!paused && sent > 100) begin
					wait_for_results();
					paused = 1'b1;
				end
			end
		end

		wait_for_results();
		repeat (10) @(posedge clk);
		if (sb.errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

@@ filelist.f @@
src/slp_pkg.sv
src/slp_if.sv
src/sms_list_response_parser.sv
tb/tb_sms_list_response_parser.sv
